>>> design/vector3_normalize_assert.svh
// Assertion macros used by the vector3_normalize checker.
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector3_normalize assertion failed");

// Next-cycle implication, disabled during reset.
`define VN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector3_normalize assertion failed");

`endif

>>> design/vn_pkg.sv
// Package: payload types and pipeline constants for vector3_normalize.
`default_nettype none
package vn_pkg;

  localparam int CompW    = 32;
  localparam int FracBits = 16;
  localparam int SqW      = 2 * CompW;
  localparam int RootW    = SqW / 2;
  localparam int RootSteps = RootW;
  localparam int QuotW    = FracBits + 1;
  localparam int RemW     = CompW + FracBits + 1;
  localparam int DivDepth = QuotW + 1;
  localparam int LenW     = 33;
  // square stage, sum stage, root stages, divider stages
  localparam int PipeDepth = 2 + RootSteps + DivDepth;
  localparam int DivStart  = 2 + RootSteps;

  localparam int AddrW = 3;
  localparam int DataW = 64;

  localparam logic [AddrW-1:0] MinLengthAddr = '0;

  typedef struct packed {
    logic signed [CompW-1:0] vec_x;
    logic signed [CompW-1:0] vec_y;
    logic signed [CompW-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [CompW-1:0] out_x;
    logic signed [CompW-1:0] out_y;
    logic signed [CompW-1:0] out_z;
    logic                    was_scaled;
  } out_t;

  function automatic logic [CompW-1:0] magnitude(input logic [CompW-1:0] v);
    magnitude = v[CompW-1] ? (~v + CompW'(1)) : v;
  endfunction

endpackage
`default_nettype wire

>>> design/vn_sq_lane.sv
// One lane: magnitude of a component and its registered square.
`default_nettype none
module vn_sq_lane (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [vn_pkg::CompW-1:0]    comp_i,
  output logic      [vn_pkg::SqW-1:0]      sq_o
);
  logic [vn_pkg::CompW-1:0] mag;
  logic [vn_pkg::SqW-1:0]   sq_q;

  assign mag = vn_pkg::magnitude(comp_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= vn_pkg::SqW'(mag) * vn_pkg::SqW'(mag);
    end
  end

  assign sq_o = sq_q;
endmodule
`default_nettype wire

>>> design/vn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vn_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [vn_pkg::SqW-1:0]      sum_i,
  output logic      [vn_pkg::RootW-1:0]    root_o
);
  logic [vn_pkg::SqW-1:0] v_q [vn_pkg::RootSteps];
  logic [vn_pkg::SqW-1:0] r_q [vn_pkg::RootSteps];

  for (genvar k = 0; k < vn_pkg::RootSteps; k++) begin : g_stage
    localparam logic [vn_pkg::SqW-1:0] Bit = vn_pkg::SqW'(1) << (vn_pkg::SqW - 2 - 2 * k);
    logic [vn_pkg::SqW-1:0] v_in, r_in, trial;

    if (k == 0) begin : g_first
      assign v_in = sum_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + Bit;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[vn_pkg::RootSteps-1][vn_pkg::RootW-1:0];
endmodule
`default_nettype wire

>>> design/vn_div_lane.sv
// One lane: pipelined restoring divide of (|comp| << 16) by the length.
`default_nettype none
module vn_div_lane (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [vn_pkg::CompW-1:0]    comp_i,
  input  wire logic [vn_pkg::RootW-1:0]    len_i,
  output logic      [vn_pkg::QuotW-1:0]    quot_o,
  output logic                             neg_o
);
  localparam int N = vn_pkg::QuotW;

  logic [vn_pkg::RemW-1:0]  rem_q [N+1];
  logic [vn_pkg::RootW-1:0] len_q [N+1];
  logic [N-1:0]             quo_q [N+1];
  logic                     neg_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= vn_pkg::RemW'({vn_pkg::magnitude(comp_i), vn_pkg::FracBits'(0)});
      len_q[0] <= len_i;
      quo_q[0] <= '0;
      neg_q[0] <= comp_i[vn_pkg::CompW-1];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int B = N - 1 - j;
    logic [vn_pkg::RemW-1:0] dsh;
    assign dsh = vn_pkg::RemW'(len_q[j]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j+1] <= len_q[j];
        neg_q[j+1] <= neg_q[j];
        if (rem_q[j] >= dsh) begin
          rem_q[j+1] <= rem_q[j] - dsh;
          quo_q[j+1] <= quo_q[j] | (N'(1) << B);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
      end
    end
  end

  assign quot_o = quo_q[N];
  assign neg_o  = neg_q[N];
endmodule
`default_nettype wire

>>> design/vector3_normalize.sv
// Top level: pipelined Q16.16 3D vector normalization.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------
//  in       | in_valid_i / in_stall_o   | in_data_i  (vn_pkg::in_t)
//  out      | out_valid_o / out_stall_i | out_data_o (vn_pkg::out_t)
//  config   | APB psel/penable/pwrite   | min_length, 33 bits at 0x0
//
// One vector per cycle while in_stall_o is low.
// Depth set by the 32-stage square root and the 18-stage dividers.
// Reset clears valid flags and min_length; no clearing pass.
// A stalled result sits in the output register, one more in a skid stage;
// in_stall_o rises only while the skid stage is full.
`default_nettype none
module vector3_normalize (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire vn_pkg::in_t                 in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output vn_pkg::out_t                     out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vn_pkg::AddrW-1:0]    paddr,
  input  wire logic [vn_pkg::DataW-1:0]    pwdata,
  output logic      [vn_pkg::DataW-1:0]    prdata,
  output logic                             pready
);
  localparam int D = vn_pkg::PipeDepth;

  logic [vn_pkg::LenW-1:0] min_length_q;
  logic                    en;
  logic [D-1:0]            valid_q;
  vn_pkg::in_t             pay_q [D];
  logic                    scale_q [vn_pkg::DivDepth];
  logic [vn_pkg::SqW-1:0]  sq_x, sq_y, sq_z, sum_q;
  logic [vn_pkg::RootW-1:0] len;
  logic [vn_pkg::QuotW-1:0] qx, qy, qz;
  logic                    nx, ny, nz;
  vn_pkg::out_t            res, out_q, skid_q;
  logic                    out_valid_q, skid_valid_q, take;

  // Config register min_length at address 0.
  assign pready = 1'b1;
  assign prdata = vn_pkg::DataW'(min_length_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
    end else if (psel && penable && pwrite && paddr == vn_pkg::MinLengthAddr) begin
      min_length_q <= pwdata[vn_pkg::LenW-1:0];
    end
  end

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  vn_sq_lane u_sq_x (.clk_i, .en_i(en), .comp_i(in_data_i.vec_x), .sq_o(sq_x));
  vn_sq_lane u_sq_y (.clk_i, .en_i(en), .comp_i(in_data_i.vec_y), .sq_o(sq_y));
  vn_sq_lane u_sq_z (.clk_i, .en_i(en), .comp_i(in_data_i.vec_z), .sq_o(sq_z));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_x + sq_y + sq_z;
    end
  end

  vn_isqrt u_isqrt (.clk_i, .en_i(en), .sum_i(sum_q), .root_o(len));

  vn_div_lane u_div_x (.clk_i, .en_i(en), .comp_i(pay_q[vn_pkg::DivStart-1].vec_x),
                       .len_i(len), .quot_o(qx), .neg_o(nx));
  vn_div_lane u_div_y (.clk_i, .en_i(en), .comp_i(pay_q[vn_pkg::DivStart-1].vec_y),
                       .len_i(len), .quot_o(qy), .neg_o(ny));
  vn_div_lane u_div_z (.clk_i, .en_i(en), .comp_i(pay_q[vn_pkg::DivStart-1].vec_z),
                       .len_i(len), .quot_o(qz), .neg_o(nz));

  // Side pipeline: raw vector, scale flags and valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[D-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0]   <= in_data_i;
      scale_q[0] <= {1'b0, len} > min_length_q;
      for (int i = 1; i < D; i++) begin
        pay_q[i] <= pay_q[i-1];
      end
      for (int i = 1; i < vn_pkg::DivDepth; i++) begin
        scale_q[i] <= scale_q[i-1];
      end
    end
  end

  // Merge lanes: signed quotient or the untouched vector.
  always_comb begin
    logic [vn_pkg::CompW-1:0] ux, uy, uz;
    ux = vn_pkg::CompW'(qx);
    uy = vn_pkg::CompW'(qy);
    uz = vn_pkg::CompW'(qz);
    if (scale_q[vn_pkg::DivDepth-1]) begin
      res.out_x      = nx ? -ux : ux;
      res.out_y      = ny ? -uy : uy;
      res.out_z      = nz ? -uz : uz;
      res.was_scaled = 1'b1;
    end else begin
      res.out_x      = pay_q[D-1].vec_x;
      res.out_y      = pay_q[D-1].vec_y;
      res.out_z      = pay_q[D-1].vec_z;
      res.was_scaled = 1'b0;
    end
  end

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (valid_q[D-1]) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (valid_q[D-1]) begin
      if (out_valid_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

>>> design/vector3_normalize_chk.sv
// Port-level checker for vector3_normalize, bound to the top level.
`default_nettype none
`include "vector3_normalize_assert.svh"
module vector3_normalize_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_stall_o,
  input wire logic         out_valid_o,
  input wire logic         out_stall_i,
  input wire vn_pkg::out_t out_data_o
);
  logic signed [vn_pkg::CompW-1:0] one_q;
  logic                            unit_ok;
  assign one_q = vn_pkg::CompW'(1) << vn_pkg::FracBits;
  assign unit_ok = out_data_o.out_x <= one_q && out_data_o.out_x >= -one_q &&
                   out_data_o.out_y <= one_q && out_data_o.out_y >= -one_q &&
                   out_data_o.out_z <= one_q && out_data_o.out_z >= -one_q;

  `VN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `VN_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  // Input stalls only when a result is already parked at the output.
  `VN_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o)
  // A scaled transaction stays in range: no component beyond 1.0.
  `VN_ASSERT_IMP(a_unit_range, clk_i, rst_ni, out_valid_o && out_data_o.was_scaled, unit_ok)
endmodule

bind vector3_normalize vector3_normalize_chk u_chk (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
`default_nettype wire

>>> verif/vector3_normalize_tb.sv
// Testbench for vector3_normalize: directed table plus random vectors, scoreboarded.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_tb;

  localparam int Latency    = 52;
  localparam int CycleLimit = 400000;
  localparam int NumRandom  = 1720;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  vn_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vn_pkg::out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vn_pkg::AddrW-1:0] paddr = '0;
  logic [vn_pkg::DataW-1:0] pwdata = '0;
  logic [vn_pkg::DataW-1:0] prdata;
  logic pready;

  vector3_normalize dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: copy of the threshold register.
  logic [vn_pkg::LenW-1:0] min_len_q = '0;
  vn_pkg::out_t expected_q[$];
  int   mismatches = 0;
  int   checked = 0;
  int   scaled_seen = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] unit_comp(input logic [31:0] v, input logic [63:0] len);
    logic [63:0] q;
    q = ({32'd0, abs32(v)} << 16) / len;
    if (v[31]) q = ~q + 64'd1;
    return q[31:0];
  endfunction

  function automatic vn_pkg::out_t normalize(input vn_pkg::in_t v);
    vn_pkg::out_t r;
    logic [63:0] mx, my, mz, len;
    mx = {32'd0, abs32(v.vec_x)};
    my = {32'd0, abs32(v.vec_y)};
    mz = {32'd0, abs32(v.vec_z)};
    len = root64(mx * mx + my * my + mz * mz);
    if (len > {31'd0, min_len_q}) begin
      r.out_x = unit_comp(v.vec_x, len);
      r.out_y = unit_comp(v.vec_y, len);
      r.out_z = unit_comp(v.vec_z, len);
      r.was_scaled = 1'b1;
    end else begin
      r.out_x = v.vec_x;
      r.out_y = v.vec_y;
      r.out_z = v.vec_z;
      r.was_scaled = 1'b0;
    end
    return r;
  endfunction

  // Output side: random wait per transaction, a long hold-off on request, compare on accept.
  initial begin
    int wait_left;
    vn_pkg::out_t want;
    wait_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", out_data_o);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.was_scaled) scaled_seen++;
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [vn_pkg::LenW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= vn_pkg::MinLengthAddr; pwdata <= {31'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    min_len_q = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one vector, after a random gap when idle is set; queue its predicted result.
  task automatic send_vector(input vn_pkg::in_t v, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(normalize(v));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  typedef struct {
    vn_pkg::in_t  v;
    bit           known;
    vn_pkg::out_t res;
  } vec_row_t;

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 131072) - 32'd65536;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_fff0 + $urandom_range(0, 15);
      3: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    vec_row_t rows[$];
    vec_row_t r;
    vn_pkg::in_t v;
    logic [vn_pkg::LenW-1:0] thresholds[5];
    rows.push_back('{'{32'd0, 32'd0, 32'd0}, 1, '{32'd0, 32'd0, 32'd0, 1'b0}});
    rows.push_back('{'{32'd65536, 32'd0, 32'd0}, 1, '{32'd65536, 32'd0, 32'd0, 1'b1}});
    rows.push_back('{'{32'd0, -32'sd65536, 32'd0}, 1,
                     '{32'd0, -32'sd65536, 32'd0, 1'b1}});
    rows.push_back('{'{32'd0, 32'd0, 32'h8000_0000}, 1, '{32'd0, 32'd0, -32'sd65536, 1'b1}});
    rows.push_back('{'{32'd0, 32'd0, 32'h7fff_ffff}, 1, '{32'd0, 32'd0, 32'd65536, 1'b1}});
    rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, '0});
    rows.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 0, '0});
    rows.push_back('{'{32'h7fff_ffff, 32'h8000_0000, 32'd1}, 0, '0});
    rows.push_back('{'{32'd1, 32'd0, 32'd0}, 1, '{32'd65536, 32'd0, 32'd0, 1'b1}});
    rows.push_back('{'{32'd3, 32'd4, 32'd0}, 0, '0});
    rows.push_back('{'{-32'sd3, 32'd4, -32'sd12}, 0, '0});
    rows.push_back('{'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, '0});
    rows.push_back('{'{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f}, 0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // threshold at reset is zero
    foreach (rows[i]) begin
      r = rows[i];
      if (r.known && normalize(r.v) !== r.res) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_vector(r.v, 1'b1);
    end
    drain();

    // length equal to threshold passes; threshold one below scales
    apb_write(33'd327680);
    send_vector('{32'd196608, 32'd262144, 32'd0}, 1'b0);
    drain();
    apb_write(33'd327679);
    send_vector('{32'd196608, 32'd262144, 32'd0}, 1'b0);
    drain();
    apb_write(33'h1_ffff_ffff);
    send_vector('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
    drain();

    // long receiver hold-off while vectors keep coming
    apb_write(33'd0);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (120) begin
        v = '{rand_comp(), rand_comp(), rand_comp()};
        send_vector(v, 1'b0);
      end
    join
    drain();

    thresholds = '{33'd0, 33'd65536, 33'd16777216, 33'h0_8000_0000, 33'h1_ffff_ffff};
    for (int p = 0; p < 8; p++) begin
      if (p < 5) apb_write(thresholds[p]);
      else apb_write({1'b0, 32'($urandom())} >> $urandom_range(0, 31));
      for (int n = 0; n < NumRandom / 8; n++) begin
        v = '{rand_comp(), rand_comp(), rand_comp()};
        send_vector(v, ($urandom_range(0, 9) < 7) && (p % 3 != 2));
      end
      drain();
    end

    repeat (Latency + 20) @(posedge clk_i);
    $display("checked %0d results, %0d scaled, %0d mismatches", checked, scaled_seen,
             mismatches);
    $display("covered zero, extreme and threshold-edge vectors across several thresholds");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/vn_pkg.sv
design/vn_sq_lane.sv
design/vn_isqrt.sv
design/vn_div_lane.sv
design/vector3_normalize.sv
design/vector3_normalize_chk.sv
verif/vector3_normalize_tb.sv
